// ===== src/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle port check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle port check failed");

`endif

// ===== src/rvcb_pkg.sv =====
// package: widths, register indexes and payload types of the vignette blend block
`timescale 1ns / 1ps

package rvcb_pkg;

	localparam int COORD_BITS = 12;
	localparam int SIZE_W     = 13;
	localparam int DIFF_W     = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
	localparam int D2_W       = 2 * DIFF_W + 1;
	localparam int RECIP_W    = 40;
	localparam int RECIP_HALF = RECIP_W / 2;
	localparam int Q16_W      = 17;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int INTEN_W    = 17;

	localparam logic [Q16_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [Q16_W-1:0] ALPHA_MIN = 17'd656;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED       = 3'd0,
		REG_GREEN     = 3'd1,
		REG_BLUE      = 3'd2,
		REG_INTENSITY = 3'd3,
		REG_WIDTH     = 3'd4,
		REG_HEIGHT    = 3'd5,
		REG_RECIP     = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [PIX_W-1:0]      pixel_in;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             was_blended;
	} pix_out_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [INTEN_W-1:0] intensity;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [RECIP_W-1:0] recip;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [D2_W-1:0]  d2;
	} dist_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [Q16_W-1:0] edge_w;
	} weight_t;

endpackage

// ===== src/radial_vignette_color_blend_top.sv =====
// path: registered stages s1 to s7 in order; a stall holds a pixel in its stage
// throughput: one pixel per cycle unless stalled; per stage a register and a valid bit
// the 40-bit reciprocal is split in two 20-bit halves, products summed a stage later
// reset: asynchronous active low, clears valid bits and loads register reset values
// config port is always ready and takes one write per cycle
`timescale 1ns / 1ps

module radial_vignette_color_blend_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rvcb_pkg::pix_in_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rvcb_pkg::pix_out_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rvcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rvcb_pkg::RECIP_W-1:0]      cfg_data
);

	rvcb_pkg::cfg_t    cfg_q;
	logic              dist_ready, dist_valid, wt_ready, wt_valid, bl_ready;
	rvcb_pkg::dist_t   dist_data;
	rvcb_pkg::weight_t wt_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red       <= 8'd255;
			cfg_q.green     <= 8'd0;
			cfg_q.blue      <= 8'd0;
			cfg_q.intensity <= 17'd0;
			cfg_q.width     <= 13'd640;
			cfg_q.height    <= 13'd480;
			cfg_q.recip     <= 40'd1717986;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rvcb_pkg::reg_index_t'(cfg_index))
				rvcb_pkg::REG_RED:       cfg_q.red       <= cfg_data[7:0];
				rvcb_pkg::REG_GREEN:     cfg_q.green     <= cfg_data[7:0];
				rvcb_pkg::REG_BLUE:      cfg_q.blue      <= cfg_data[7:0];
				rvcb_pkg::REG_INTENSITY: cfg_q.intensity <= cfg_data[16:0];
				rvcb_pkg::REG_WIDTH:     cfg_q.width     <= cfg_data[12:0];
				rvcb_pkg::REG_HEIGHT:    cfg_q.height    <= cfg_data[12:0];
				rvcb_pkg::REG_RECIP:     cfg_q.recip     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !dist_ready;

	rvcb_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (dist_ready),
		.in_data   (in_data),
		.out_valid (dist_valid),
		.out_ready (wt_ready),
		.out_data  (dist_data)
	);

	rvcb_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (dist_valid),
		.in_ready  (wt_ready),
		.in_data   (dist_data),
		.out_valid (wt_valid),
		.out_ready (bl_ready),
		.out_data  (wt_data)
	);

	rvcb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (wt_valid),
		.in_ready  (bl_ready),
		.in_data   (wt_data),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== src/rvcb_dist.sv =====
// squared distance from frame center in half-pixel units, three stages
`timescale 1ns / 1ps

module rvcb_dist (
	input  logic               clk,
	input  logic               arst_n,
	input  rvcb_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvcb_pkg::pix_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rvcb_pkg::dist_t    out_data
);

	localparam int DW = rvcb_pkg::DIFF_W;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     ready_s1, ready_s2, ready_s3;
	logic [DW-1:0]            dx_s1, dy_s1;
	logic [rvcb_pkg::PIX_W-1:0] pix_s1, pix_s2;
	logic [2*DW-1:0]          sqx_s2, sqy_s2;
	rvcb_pkg::dist_t          res_s3;

	logic [DW:0] tx, ty, wx, hy, dx, dy;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		tx = (DW + 1)'({in_data.pixel_x, 1'b0});
		ty = (DW + 1)'({in_data.pixel_y, 1'b0});
		wx = (DW + 1)'(cfg.width);
		hy = (DW + 1)'(cfg.height);
		dx = (tx >= wx) ? (tx - wx) : (wx - tx);
		dy = (ty >= hy) ? (ty - hy) : (hy - ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			dx_s1  <= dx[DW-1:0];
			dy_s1  <= dy[DW-1:0];
			pix_s1 <= in_data.pixel_in;
		end
		if (ready_s2) begin
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			pix_s2 <= pix_s1;
		end
		if (ready_s3) begin
			res_s3.d2    <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			res_s3.pixel <= pix_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = res_s3;

endmodule

// ===== src/rvcb_weight.sv =====
// normalized edge weight: product with the split 40-bit reciprocal and saturation, two stages
`timescale 1ns / 1ps

module rvcb_weight (
	input  logic              clk,
	input  logic              arst_n,
	input  rvcb_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvcb_pkg::dist_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rvcb_pkg::weight_t out_data
);

	localparam int D2W    = rvcb_pkg::D2_W;
	localparam int HALF   = rvcb_pkg::RECIP_HALF;
	localparam int RW     = rvcb_pkg::RECIP_W;
	localparam int PART_W = D2W + HALF;
	localparam int PROD_W = D2W + RW;

	logic                       valid_s4, valid_s5;
	logic                       ready_s4, ready_s5;
	logic [PART_W-1:0]          lo_s4, hi_s4;
	logic [rvcb_pkg::PIX_W-1:0] pix_s4;
	rvcb_pkg::weight_t          res_s5;

	logic [PROD_W-1:0] prod;
	logic              sat;

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign in_ready = ready_s4;

	always_comb begin
		prod = {hi_s4, {HALF{1'b0}}} + PROD_W'(lo_s4);
		sat  = |prod[PROD_W-1:RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) valid_s4 <= in_valid;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			lo_s4  <= in_data.d2 * cfg.recip[HALF-1:0];
			hi_s4  <= in_data.d2 * cfg.recip[RW-1:HALF];
			pix_s4 <= in_data.pixel;
		end
		if (ready_s5) begin
			res_s5.edge_w <= sat ? rvcb_pkg::ONE_Q16 : {1'b0, prod[RW-1:RW-16]};
			res_s5.pixel  <= pix_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = res_s5;

endmodule

// ===== src/rvcb_blend.sv =====
// alpha from intensity, threshold and per-channel color mix, two stages
`timescale 1ns / 1ps

module rvcb_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  rvcb_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvcb_pkg::weight_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rvcb_pkg::pix_out_t out_data
);

	localparam int QW = rvcb_pkg::Q16_W;
	localparam int CW = rvcb_pkg::CHAN_W;
	localparam int MW = 2 * QW;
	localparam int AW = CW + QW;

	function automatic logic [CW-1:0] mix(input logic [CW-1:0] p, input logic [CW-1:0] c,
		input logic [QW-1:0] a);
		logic [AW-1:0] acc;
		acc = AW'(p) * AW'(rvcb_pkg::ONE_Q16 - a) + AW'(c) * AW'(a);
		return acc[AW-2:AW-1-CW];
	endfunction

	logic                       valid_s6, valid_s7;
	logic                       ready_s6, ready_s7;
	logic [QW-1:0]              alpha_s6;
	logic [rvcb_pkg::PIX_W-1:0] pix_s6;
	rvcb_pkg::pix_out_t         res_s7;

	logic [QW-1:0] inten;
	logic [MW-1:0] prod;
	logic          blend;

	assign ready_s7 = !valid_s7 || out_ready;
	assign ready_s6 = !valid_s6 || ready_s7;
	assign in_ready = ready_s6;

	always_comb begin
		inten = (cfg.intensity > rvcb_pkg::ONE_Q16) ? rvcb_pkg::ONE_Q16 : cfg.intensity;
		prod  = in_data.edge_w * inten;
		blend = (alpha_s6 >= rvcb_pkg::ALPHA_MIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (ready_s6) valid_s6 <= in_valid;
			if (ready_s7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6) begin
			alpha_s6 <= prod[QW+15:16];
			pix_s6   <= in_data.pixel;
		end
		if (ready_s7) begin
			res_s7.was_blended <= blend;
			if (blend) begin
				res_s7.pixel_out <= {8'h00,
					mix(pix_s6[23:16], cfg.red, alpha_s6),
					mix(pix_s6[15:8], cfg.green, alpha_s6),
					mix(pix_s6[7:0], cfg.blue, alpha_s6)};
			end else begin
				res_s7.pixel_out <= pix_s6;
			end
		end
	end

	assign out_valid = valid_s7;
	assign out_data  = res_s7;

endmodule

// ===== src/rvcb_checker.sv =====
// port checker for the vignette blend top level and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rvcb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input rvcb_pkg::pix_out_t out_data,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// a free output side never backs up the input
	`ASSERT_IMP(a_no_bubble_stall, clk, arst_n, !out_stall, !in_stall)
	// blended pixels have their top byte cleared
	`ASSERT_IMP(a_blend_top_zero, clk, arst_n, out_valid && out_data.was_blended, out_data.pixel_out[31:24] == 8'h00)
	// a stalled result holds until its transfer
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	// config writes are never refused
	`ASSERT_IMP(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind radial_vignette_color_blend_top rvcb_checker u_rvcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// ===== sim/rvcb_checker.sv =====
// checker for the vignette blend block: tracks the registers, predicts each pixel, compares
`timescale 1ns / 1ps

module rvcb_tb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  rvcb_pkg::pix_in_t              in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  rvcb_pkg::pix_out_t             out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rvcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rvcb_pkg::RECIP_W-1:0]   cfg_data,
	output int                             mismatch_count,
	output int                             pending_count
);

	localparam logic [63:0] UNITY       = 64'(rvcb_pkg::ONE_Q16);
	localparam logic [63:0] PRODUCT_MAX = (64'd1 << rvcb_pkg::RECIP_W) - 64'd1;
	localparam rvcb_pkg::cfg_t CFG_RESET = '{
		red:       8'd255,
		green:     8'd0,
		blue:      8'd0,
		intensity: 17'd0,
		width:     13'd640,
		height:    13'd480,
		recip:     40'd1717986
	};

	rvcb_pkg::cfg_t     regs;
	rvcb_pkg::pix_out_t blend_queue[$];

	function automatic logic [63:0] centered_sq(input logic [63:0] pos,
			input logic [63:0] size);
		logic [63:0] twice;
		logic [63:0] diff;
		twice = pos << 1;
		diff  = (twice >= size) ? twice - size : size - twice;
		return diff * diff;
	endfunction

	function automatic logic [rvcb_pkg::CHAN_W-1:0] mix_channel(input logic [63:0] p,
			input logic [63:0] c, input logic [63:0] alpha);
		logic [63:0] acc;
		acc = p * (UNITY - alpha) + c * alpha;
		return acc[23:16];
	endfunction

	function automatic rvcb_pkg::pix_out_t predict_blend(input rvcb_pkg::cfg_t c,
			input rvcb_pkg::pix_in_t p);
		logic [63:0]        d2;
		logic [63:0]        prod;
		logic [63:0]        edge_w;
		logic [63:0]        inten;
		logic [63:0]        alpha;
		rvcb_pkg::pix_out_t r;
		d2 = centered_sq(64'(p.pixel_x), 64'(c.width))
			+ centered_sq(64'(p.pixel_y), 64'(c.height));
		if (d2 == 0 || c.recip == 0)
			edge_w = 0;
		else if (64'(c.recip) > PRODUCT_MAX / d2)
			edge_w = UNITY;
		else begin
			prod   = (d2 * 64'(c.recip)) >> 24;
			edge_w = (prod > UNITY) ? UNITY : prod;
		end
		inten = (64'(c.intensity) > UNITY) ? UNITY : 64'(c.intensity);
		alpha = (edge_w * inten) >> 16;
		if (alpha >= 64'(rvcb_pkg::ALPHA_MIN)) begin
			r.pixel_out = {8'h00,
				mix_channel(64'(p.pixel_in[23:16]), 64'(c.red), alpha),
				mix_channel(64'(p.pixel_in[15:8]), 64'(c.green), alpha),
				mix_channel(64'(p.pixel_in[7:0]), 64'(c.blue), alpha)};
			r.was_blended = 1'b1;
		end else begin
			r.pixel_out   = p.pixel_in;
			r.was_blended = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rvcb_pkg::pix_out_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			blend_queue.delete();
			pending_count  = 0;
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rvcb_pkg::REG_RED:
						regs.red = cfg_data[rvcb_pkg::CHAN_W-1:0];
					rvcb_pkg::REG_GREEN:
						regs.green = cfg_data[rvcb_pkg::CHAN_W-1:0];
					rvcb_pkg::REG_BLUE:
						regs.blue = cfg_data[rvcb_pkg::CHAN_W-1:0];
					rvcb_pkg::REG_INTENSITY:
						regs.intensity = cfg_data[rvcb_pkg::INTEN_W-1:0];
					rvcb_pkg::REG_WIDTH:
						regs.width = cfg_data[rvcb_pkg::SIZE_W-1:0];
					rvcb_pkg::REG_HEIGHT:
						regs.height = cfg_data[rvcb_pkg::SIZE_W-1:0];
					rvcb_pkg::REG_RECIP:
						regs.recip = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				blend_queue.insert(blend_queue.size(), predict_blend(regs, in_data));
			if (out_valid && !out_stall) begin
				if (blend_queue.size() == 0)
					report_mismatch("result transfer with none expected", 64'd0,
						64'(out_data.pixel_out));
				else begin
					want = blend_queue.pop_front();
					if (out_data.pixel_out !== want.pixel_out)
						report_mismatch("pixel_out", 64'(want.pixel_out),
							64'(out_data.pixel_out));
					if (out_data.was_blended !== want.was_blended)
						report_mismatch("was_blended", 64'(want.was_blended),
							64'(out_data.was_blended));
				end
			end
			pending_count = blend_queue.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the vignette blend block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

	localparam logic [rvcb_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int SETTLE_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT  = 5000;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	rvcb_pkg::pix_in_t              in_data   = '0;
	logic                           out_stall = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [rvcb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rvcb_pkg::RECIP_W-1:0]   cfg_data  = '0;
	logic                           in_stall;
	logic                           out_valid;
	rvcb_pkg::pix_out_t             out_data;
	logic                           cfg_ready;
	int                             mismatch_count;
	int                             pending_count;
	int                             send_gap_pct = 0;
	int                             stall_pct    = 0;
	int                             quiet_cycles = 0;

	radial_vignette_color_blend_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rvcb_tb_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic rvcb_pkg::pix_in_t pixel_at(input int x, input int y,
			input logic [rvcb_pkg::PIX_W-1:0] pix);
		rvcb_pkg::pix_in_t p;
		p.pixel_x  = x[rvcb_pkg::COORD_BITS-1:0];
		p.pixel_y  = y[rvcb_pkg::COORD_BITS-1:0];
		p.pixel_in = pix;
		return p;
	endfunction

	function automatic logic [rvcb_pkg::CHAN_W-1:0] rand_color();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			default: return rvcb_pkg::CHAN_W'($urandom);
		endcase
	endfunction

	function automatic logic [rvcb_pkg::SIZE_W-1:0] rand_size();
		case ($urandom_range(7))
			0:       return 13'd1;
			1:       return 13'd4096;
			2:       return rvcb_pkg::SIZE_W'($urandom);
			default: return rvcb_pkg::SIZE_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// random bits above the register width now and then
	function automatic logic [rvcb_pkg::RECIP_W-1:0] cfg_word(
			input logic [rvcb_pkg::RECIP_W-1:0] value, input int bits);
		logic [rvcb_pkg::RECIP_W-1:0] mask;
		logic [rvcb_pkg::RECIP_W-1:0] junk;
		mask = (40'd1 << bits) - 40'd1;
		junk = rvcb_pkg::RECIP_W'({$urandom, $urandom});
		return ($urandom_range(1) == 0) ? value : (value & mask) | (junk & ~mask);
	endfunction

	function automatic rvcb_pkg::cfg_t random_setting();
		rvcb_pkg::cfg_t s;
		logic [63:0]    span;
		logic [63:0]    q;
		s.red   = rand_color();
		s.green = rand_color();
		s.blue  = rand_color();
		case ($urandom_range(7))
			0:       s.intensity = rvcb_pkg::ONE_Q16;
			1:       s.intensity = '0;
			2:       s.intensity = '1;
			default: s.intensity = rvcb_pkg::INTEN_W'($urandom_range(65536));
		endcase
		s.width  = rand_size();
		s.height = rand_size();
		span = 64'(s.width) * 64'(s.width) + 64'(s.height) * 64'(s.height);
		case ($urandom_range(9))
			0:       s.recip = '0;
			1:       s.recip = rvcb_pkg::RECIP_W'({$urandom, $urandom});
			default: begin
				q = (span == 0) ? 64'hFF_FFFF_FFFF : (64'd1 << rvcb_pkg::RECIP_W) / span;
				s.recip = (q > 64'hFF_FFFF_FFFF) ? '1 : q[rvcb_pkg::RECIP_W-1:0];
			end
		endcase
		return s;
	endfunction

	function automatic rvcb_pkg::pix_in_t random_pixel(input rvcb_pkg::cfg_t s);
		rvcb_pkg::pix_in_t p;
		p.pixel_in = $urandom;
		if ($urandom_range(4) == 0 || s.width == 0 || s.height == 0) begin
			p.pixel_x = rvcb_pkg::COORD_BITS'($urandom);
			p.pixel_y = rvcb_pkg::COORD_BITS'($urandom);
		end else begin
			p.pixel_x = rvcb_pkg::COORD_BITS'(
				$urandom_range(((s.width > 4096) ? 4096 : s.width) - 1));
			p.pixel_y = rvcb_pkg::COORD_BITS'(
				$urandom_range(((s.height > 4096) ? 4096 : s.height) - 1));
		end
		return p;
	endfunction

	task automatic send_pixel(input rvcb_pkg::pix_in_t item);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rvcb_pkg::CFG_IDX_W-1:0] idx,
			input logic [rvcb_pkg::RECIP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(input rvcb_pkg::cfg_t s);
		write_reg(rvcb_pkg::REG_RED, cfg_word(40'(s.red), rvcb_pkg::CHAN_W));
		write_reg(rvcb_pkg::REG_GREEN, cfg_word(40'(s.green), rvcb_pkg::CHAN_W));
		write_reg(rvcb_pkg::REG_BLUE, cfg_word(40'(s.blue), rvcb_pkg::CHAN_W));
		write_reg(rvcb_pkg::REG_INTENSITY, cfg_word(40'(s.intensity), rvcb_pkg::INTEN_W));
		write_reg(rvcb_pkg::REG_WIDTH, cfg_word(40'(s.width), rvcb_pkg::SIZE_W));
		write_reg(rvcb_pkg::REG_HEIGHT, cfg_word(40'(s.height), rvcb_pkg::SIZE_W));
		write_reg(rvcb_pkg::REG_RECIP, s.recip);
	endtask

	initial begin
		rvcb_pkg::cfg_t setting;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting has zero intensity
		send_pixel(pixel_at(0, 0, 32'hFFFF_FFFF));
		send_pixel(pixel_at(4095, 4095, 32'h0000_0000));
		wait_all_results();

		write_reg(rvcb_pkg::REG_RED, 40'h00);
		write_reg(rvcb_pkg::REG_GREEN, 40'hFF);
		write_reg(rvcb_pkg::REG_BLUE, 40'h5A);
		write_reg(rvcb_pkg::REG_INTENSITY, 40'h1_0000);
		send_pixel(pixel_at(320, 240, 32'hFF12_3456));
		send_pixel(pixel_at(0, 0, 32'hFFFF_FFFF));
		send_pixel(pixel_at(639, 479, 32'h0000_0000));
		send_pixel(pixel_at(4095, 4095, 32'hAB00_FF00));
		// either side of the blend threshold
		send_pixel(pixel_at(360, 240, 32'h00FF_FFFF));
		send_pixel(pixel_at(361, 240, 32'h00FF_FFFF));
		wait_all_results();

		// intensity above one
		write_reg(rvcb_pkg::REG_INTENSITY, 40'h1_FFFF);
		send_pixel(pixel_at(0, 0, 32'h8080_8080));
		send_pixel(pixel_at(100, 50, 32'h7F7F_7F7F));
		wait_all_results();

		write_reg(rvcb_pkg::REG_RECIP, 40'h0);
		send_pixel(pixel_at(0, 0, 32'h1234_5678));
		wait_all_results();

		// empty frame with full-scale normalization
		write_reg(rvcb_pkg::REG_WIDTH, 40'h0);
		write_reg(rvcb_pkg::REG_HEIGHT, 40'h0);
		write_reg(rvcb_pkg::REG_RECIP, 40'hFF_FFFF_FFFF);
		write_reg(rvcb_pkg::REG_RED, 40'hFF);
		write_reg(rvcb_pkg::REG_BLUE, 40'hFF);
		send_pixel(pixel_at(0, 0, 32'hDEAD_BEEF));
		send_pixel(pixel_at(1, 0, 32'h0000_0000));
		wait_all_results();

		// oversize frame, write to an unknown index
		write_reg(rvcb_pkg::REG_WIDTH, 40'h1FFF);
		write_reg(rvcb_pkg::REG_HEIGHT, 40'h1FFF);
		write_reg(REG_NONE, 40'hFF_FFFF_FFFF);
		send_pixel(pixel_at(4095, 4095, 32'h5A5A_A5A5));
		send_pixel(pixel_at(0, 0, 32'hA5A5_5A5A));
		send_pixel(pixel_at(2048, 17, 32'h0F0F_F0F0));
		wait_all_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0:       begin send_gap_pct = 0;  stall_pct = 0;  end
				1:       begin send_gap_pct = 50; stall_pct = 0;  end
				2:       begin send_gap_pct = 0;  stall_pct = 50; end
				default: begin send_gap_pct = 31; stall_pct = 31; end
			endcase
			setting = random_setting();
			load_setting(setting);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 2 && n == ITEMS_PER_PHASE / 2)
					wait_all_results();
				send_pixel(random_pixel(setting));
			end
			wait_all_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/rvcb_pkg.sv
src/rvcb_dist.sv
src/rvcb_weight.sv
src/rvcb_blend.sv
src/radial_vignette_color_blend_top.sv
src/rvcb_checker.sv
sim/rvcb_checker.sv
sim/tb_top.sv
